### hw/rtl/txtcon_pkg.sv
// Text console package: constants, mode codes, controller states and the
// command/status structs shared by the controller and datapath. No dependencies.
package txtcon_pkg;

  localparam int ROWS_DEF = 25;
  localparam int COLS_DEF = 80;

  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] LF_CHAR    = 8'h0A;
  localparam logic [7:0] CR_CHAR    = 8'h0D;
  localparam logic [7:0] ATTR_RESET = 8'h07;
  localparam logic [7:0] ATTR_INIT  = 8'h00;

  localparam int MEM_WIDTH = 16;  // {char, attr}

  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_BKSP  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCROLL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic init_wr;
    logic clr_wr;
    logic scr_wr;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic will_scroll;
    logic cnt_last;
  } ctrl_sts_t;

endpackage

### hw/rtl/txtcon_if.sv
// Valid/ready channel interfaces for the console input and result beats.
// Depends on nothing.
interface txtcon_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  char_code;
  logic [10:0] cell_index;

  modport source (output valid, output mode, output char_code, output cell_index,
                  input ready);
  modport sink (input valid, input mode, input char_code, input cell_index,
                output ready);
endinterface

interface txtcon_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  cursor_row;
  logic [6:0]  cursor_col;
  logic [10:0] cursor_offset;
  logic        scrolled;
  logic [7:0]  cell_char;
  logic [7:0]  cell_attr;

  modport source (output valid, output cursor_row, output cursor_col,
                  output cursor_offset, output scrolled, output cell_char,
                  output cell_attr, input ready);
  modport sink (input valid, input cursor_row, input cursor_col,
                input cursor_offset, input scrolled, input cell_char,
                input cell_attr, output ready);
endinterface

### hw/rtl/txtcon_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module txtcon_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/txtcon_ctrl.sv
// Console controller FSM: init sweep, accept, clear/scroll sweeps, result load.
// Depends on txtcon_pkg.
module txtcon_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [1:0]            in_mode,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  txtcon_pkg::ctrl_sts_t sts,
  output txtcon_pkg::ctrl_cmd_t cmd
);

  txtcon_pkg::state_t state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_free;
  logic               accept;

  assign out_free = !out_valid_r || out_ready;
  assign accept   = (state_r == txtcon_pkg::ST_IDLE) && in_valid;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      txtcon_pkg::ST_INIT: begin
        if (sts.cnt_last) state_nxt = txtcon_pkg::ST_IDLE;
      end
      txtcon_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_mode == txtcon_pkg::MODE_CLEAR) state_nxt = txtcon_pkg::ST_CLEAR;
          else if (sts.will_scroll)              state_nxt = txtcon_pkg::ST_SCROLL;
          else                                   state_nxt = txtcon_pkg::ST_DONE;
        end
      end
      txtcon_pkg::ST_CLEAR, txtcon_pkg::ST_SCROLL: begin
        if (sts.cnt_last) state_nxt = txtcon_pkg::ST_DONE;
      end
      txtcon_pkg::ST_DONE: begin
        if (out_free) state_nxt = txtcon_pkg::ST_IDLE;
      end
      default: state_nxt = txtcon_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.accept   = accept;
    cmd.init_wr  = (state_r == txtcon_pkg::ST_INIT);
    cmd.clr_wr   = (state_r == txtcon_pkg::ST_CLEAR);
    cmd.scr_wr   = (state_r == txtcon_pkg::ST_SCROLL);
    cmd.load_out = (state_r == txtcon_pkg::ST_DONE) && out_free;
    in_ready     = (state_r == txtcon_pkg::ST_IDLE);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)  out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= txtcon_pkg::ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hw/rtl/txtcon_dp.sv
// Console datapath: cursor, attribute register, sweep counter, frame store
// and result register. Depends on txtcon_pkg and txtcon_ram.
module txtcon_dp #(
  parameter int ROWS = txtcon_pkg::ROWS_DEF,
  parameter int COLS = txtcon_pkg::COLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_wdata,
  input  logic [1:0]            in_mode,
  input  logic [7:0]            in_char_code,
  input  logic [10:0]           in_cell_index,
  input  txtcon_pkg::ctrl_cmd_t cmd,
  output txtcon_pkg::ctrl_sts_t sts,
  output logic [4:0]            out_cursor_row,
  output logic [6:0]            out_cursor_col,
  output logic [10:0]           out_cursor_offset,
  output logic                  out_scrolled,
  output logic [7:0]            out_cell_char,
  output logic [7:0]            out_cell_attr
);

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = AW + 1;
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int KEEP  = (ROWS - 1) * COLS;
  localparam int MW    = txtcon_pkg::MEM_WIDTH;

  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic [7:0]    attr_r;
  logic [AW-1:0] cnt_r;
  logic          pend_scr_r, pend_rd_r;

  logic [4:0]    o_row_r;
  logic [6:0]    o_col_r;
  logic [10:0]   o_off_r;
  logic          o_scr_r;
  logic [7:0]    o_char_r, o_attr_r;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [MW-1:0] wdata, rdata;

  logic [AW-1:0] off_cur, bs_off;
  logic [RW-1:0] nl_row, bs_row;
  logic [CW-1:0] bs_col;
  logic          is_nl, at_last_col, at_bottom, origin, in_rng;
  logic [XW-1:0] sweep_rd;
  logic          sweep_rd_ok, sweep_wr;

  assign off_cur     = AW'(row_r) * AW'(COLS) + AW'(col_r);
  assign is_nl       = (in_char_code == txtcon_pkg::LF_CHAR) ||
                       (in_char_code == txtcon_pkg::CR_CHAR);
  assign at_last_col = (col_r == CW'(COLS - 1));
  assign at_bottom   = (row_r == RW'(ROWS - 1));
  assign nl_row      = at_bottom ? row_r : row_r + RW'(1);
  assign origin      = (row_r == '0) && (col_r == '0);
  assign bs_col      = (col_r != '0) ? col_r - CW'(1) : CW'(COLS - 1);
  assign bs_row      = (col_r != '0) ? row_r : row_r - RW'(1);
  assign bs_off      = AW'(bs_row) * AW'(COLS) + AW'(bs_col);
  assign in_rng      = 32'(in_cell_index) < 32'(CELLS);
  assign sweep_rd    = XW'(cnt_r) + XW'(COLS + 1);
  assign sweep_rd_ok = sweep_rd < XW'(CELLS);
  assign sweep_wr    = cmd.init_wr || cmd.clr_wr || cmd.scr_wr;

  assign sts.will_scroll = (in_mode == txtcon_pkg::MODE_PUT) && at_bottom &&
                           (is_nl || at_last_col);
  assign sts.cnt_last    = (cnt_r == AW'(CELLS - 1));

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    we      = 1'b0;
    waddr   = cnt_r;
    wdata   = '0;
    re      = 1'b0;
    raddr   = '0;
    if (cmd.init_wr) begin
      we    = 1'b1;
      wdata = {txtcon_pkg::BLANK_CHAR, txtcon_pkg::ATTR_INIT};
    end else if (cmd.clr_wr) begin
      we    = 1'b1;
      wdata = {txtcon_pkg::BLANK_CHAR, attr_r};
    end else if (cmd.scr_wr) begin
      we    = 1'b1;
      wdata = (32'(cnt_r) < 32'(KEEP)) ? {rdata[MW-1:8], attr_r}
                                       : {txtcon_pkg::BLANK_CHAR, attr_r};
      re    = sweep_rd_ok;
      raddr = AW'(sweep_rd);
    end else if (cmd.accept) begin
      unique case (txtcon_pkg::mode_t'(in_mode))
        txtcon_pkg::MODE_PUT: begin
          if (is_nl) begin
            row_nxt = nl_row;
            col_nxt = '0;
          end else begin
            we    = 1'b1;
            waddr = off_cur;
            wdata = {in_char_code, attr_r};
            if (at_last_col) begin
              row_nxt = nl_row;
              col_nxt = '0;
            end else begin
              col_nxt = col_r + CW'(1);
            end
          end
          if (sts.will_scroll) begin
            re    = 1'b1;
            raddr = AW'(COLS);
          end
        end
        txtcon_pkg::MODE_BKSP: begin
          if (!origin) begin
            row_nxt = bs_row;
            col_nxt = bs_col;
            we      = 1'b1;
            waddr   = bs_off;
            wdata   = {txtcon_pkg::BLANK_CHAR, attr_r};
          end
        end
        txtcon_pkg::MODE_CLEAR: begin
          row_nxt = '0;
          col_nxt = '0;
        end
        txtcon_pkg::MODE_READ: begin
          re    = in_rng;
          raddr = AW'(in_cell_index);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      attr_r <= txtcon_pkg::ATTR_RESET;
      cnt_r  <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      if (cfg_we) attr_r <= cfg_wdata;
      if (cmd.accept)    cnt_r <= '0;
      else if (sweep_wr) cnt_r <= cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pend_scr_r <= sts.will_scroll;
      pend_rd_r  <= (in_mode == txtcon_pkg::MODE_READ) && in_rng;
    end
    if (cmd.load_out) begin
      o_row_r  <= 5'(row_r);
      o_col_r  <= 7'(col_r);
      o_off_r  <= 11'(off_cur);
      o_scr_r  <= pend_scr_r;
      o_char_r <= pend_rd_r ? rdata[MW-1:8] : 8'h00;
      o_attr_r <= pend_rd_r ? rdata[7:0] : 8'h00;
    end
  end

  txtcon_ram #(
    .WIDTH(MW),
    .DEPTH(CELLS)
  ) u_frame (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign out_cursor_row    = o_row_r;
  assign out_cursor_col    = o_col_r;
  assign out_cursor_offset = o_off_r;
  assign out_scrolled      = o_scr_r;
  assign out_cell_char     = o_char_r;
  assign out_cell_attr     = o_attr_r;

endmodule

### hw/rtl/text_console_with_scroll_top.sv
// Text console top level: controller, datapath and channel hookup.
// Depends on txtcon_pkg, txtcon_if, txtcon_ctrl, txtcon_dp.
//
//  channel  dir  fields                                              beat when
//  in_if    in   mode, char_code, cell_index                         valid && ready
//  out_if   out  cursor_row/col/offset, scrolled, cell_char/attr     valid && ready
//  cfg      in   cfg_wdata (text attribute)                          cfg_we
//
// Put char without scroll, backspace and read access the store when the beat is
// accepted, then load the result. Scroll and clear sweep the frame store one
// cell per cycle. After reset the store is swept once (ROWS*COLS cells, 2000
// by default) with in_if.ready low; cfg writes are taken.
// A result parked on out_if does not block the next input beat; only its load.
module text_console_with_scroll_top #(
  parameter int ROWS = txtcon_pkg::ROWS_DEF,
  parameter int COLS = txtcon_pkg::COLS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  txtcon_in_if.sink    in_if,
  txtcon_out_if.source out_if,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata
);

  txtcon_pkg::ctrl_cmd_t cmd;
  txtcon_pkg::ctrl_sts_t sts;

  txtcon_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_mode  (in_if.mode),
    .in_ready (in_if.ready),
    .out_valid(out_if.valid),
    .out_ready(out_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  txtcon_dp #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_mode          (in_if.mode),
    .in_char_code     (in_if.char_code),
    .in_cell_index    (in_if.cell_index),
    .cmd              (cmd),
    .sts              (sts),
    .out_cursor_row   (out_if.cursor_row),
    .out_cursor_col   (out_if.cursor_col),
    .out_cursor_offset(out_if.cursor_offset),
    .out_scrolled     (out_if.scrolled),
    .out_cell_char    (out_if.cell_char),
    .out_cell_attr    (out_if.cell_attr)
  );

endmodule

### verif/text_console_with_scroll_top_tb.sv
// Testbench for text_console_with_scroll_top: drives put, backspace, clear and read beats,
// keeps a shadow frame store and cursor, and checks every result beat field by field.
// Depends on txtcon_pkg, txtcon_if and the console RTL.
module text_console_with_scroll_top_tb;

  localparam int ROWS     = txtcon_pkg::ROWS_DEF;
  localparam int COLS     = txtcon_pkg::COLS_DEF;
  localparam int CELLS    = ROWS * COLS;
  localparam int AW       = $clog2(CELLS);
  localparam int IDLE_PCT = 11;
  localparam int SWEEP    = CELLS + 10;

  typedef struct packed {
    logic [4:0]  row;
    logic [6:0]  col;
    logic [10:0] offset;
    logic        scrolled;
    logic [7:0]  ch;
    logic [7:0]  attr;
  } cursor_report_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  txtcon_in_if  in_ch ();
  txtcon_out_if out_ch ();

  text_console_with_scroll_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // shadow console
  logic [7:0]     shadow_char [CELLS];
  logic [7:0]     shadow_attr [CELLS];
  int unsigned    cur_row;
  int unsigned    cur_col;
  logic [7:0]     cur_attr;
  cursor_report_t reports_due [$];
  int             error_count = 0;
  int             beats_sent  = 0;
  bit             idle_on     = 1'b1;

  function automatic void console_reset();
    for (int i = 0; i < CELLS; i++) begin
      shadow_char[AW'(i)] = txtcon_pkg::BLANK_CHAR;
      shadow_attr[AW'(i)] = txtcon_pkg::ATTR_INIT;
    end
    cur_row  = 0;
    cur_col  = 0;
    cur_attr = txtcon_pkg::ATTR_RESET;
  endfunction

  function automatic void blank_cell(logic [AW-1:0] pos);
    shadow_char[pos] = txtcon_pkg::BLANK_CHAR;
    shadow_attr[pos] = cur_attr;
  endfunction

  // returns 1 when the screen scrolled
  function automatic bit line_feed();
    cur_col = 0;
    if (cur_row + 1 < ROWS) begin
      cur_row++;
      return 1'b0;
    end
    for (int i = 0; i < (ROWS - 1) * COLS; i++) begin
      shadow_char[AW'(i)] = shadow_char[AW'(i + COLS)];
      shadow_attr[AW'(i)] = cur_attr;
    end
    for (int i = (ROWS - 1) * COLS; i < CELLS; i++) blank_cell(AW'(i));
    return 1'b1;
  endfunction

  function automatic cursor_report_t console_step(txtcon_pkg::mode_t m, logic [7:0] ch,
                                                  logic [10:0] idx);
    cursor_report_t r;
    logic [AW-1:0]  pos;
    r = '0;
    case (m)
      txtcon_pkg::MODE_PUT: begin
        if (ch == txtcon_pkg::LF_CHAR || ch == txtcon_pkg::CR_CHAR) begin
          r.scrolled = line_feed();
        end else begin
          pos = AW'(cur_row * COLS + cur_col);
          shadow_char[pos] = ch;
          shadow_attr[pos] = cur_attr;
          cur_col++;
          if (cur_col >= COLS) r.scrolled = line_feed();
        end
      end
      txtcon_pkg::MODE_BKSP: begin
        if (cur_row != 0 || cur_col != 0) begin
          if (cur_col > 0) begin
            cur_col--;
          end else begin
            cur_row--;
            cur_col = COLS - 1;
          end
          blank_cell(AW'(cur_row * COLS + cur_col));
        end
      end
      txtcon_pkg::MODE_CLEAR: begin
        for (int i = 0; i < CELLS; i++) blank_cell(AW'(i));
        cur_row = 0;
        cur_col = 0;
      end
      txtcon_pkg::MODE_READ: begin
        if (idx < CELLS) begin
          r.ch   = shadow_char[AW'(idx)];
          r.attr = shadow_attr[AW'(idx)];
        end
      end
    endcase
    r.row    = 5'(cur_row);
    r.col    = 7'(cur_col);
    r.offset = 11'(cur_row * COLS + cur_col);
    return r;
  endfunction

  task automatic send_beat(txtcon_pkg::mode_t m, logic [7:0] ch, logic [10:0] idx);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.mode       <= m;
    in_ch.char_code  <= ch;
    in_ch.cell_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    reports_due.push_back(console_step(m, ch, idx));
    beats_sent++;
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_attr(logic [7:0] value);
    wait_quiet();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cur_attr = value;
  endtask

  task automatic put_char(logic [7:0] ch);
    send_beat(txtcon_pkg::MODE_PUT, ch, 11'($urandom_range(2047)));
  endtask

  task automatic read_cell(logic [10:0] idx);
    send_beat(txtcon_pkg::MODE_READ, 8'($urandom_range(255)), idx);
  endtask

  function automatic logic [7:0] text_char();
    logic [7:0] ch;
    do ch = 8'($urandom_range(255));
    while (ch == txtcon_pkg::LF_CHAR || ch == txtcon_pkg::CR_CHAR);
    return ch;
  endfunction

  function automatic logic [10:0] pick_cell();
    int unsigned k;
    int          here;
    k    = $urandom_range(99);
    here = int'(cur_row * COLS + cur_col - $urandom_range(0, 2));
    if (k < 70) return 11'($urandom_range(CELLS - 1));
    if (k < 85) return (here < 0) ? 11'd0 : 11'(here);
    return 11'($urandom_range(CELLS, 2047));
  endfunction

  // ---- tests ----

  task automatic test_power_up();
    read_cell(11'd0);
    read_cell(11'(CELLS - 1));
    read_cell(11'(CELLS));
    read_cell(11'h7FF);
    send_beat(txtcon_pkg::MODE_BKSP, 8'h00, 11'h000);
    read_cell(11'd0);
  endtask

  task automatic test_edit_line();
    set_attr(8'hFF);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(8'h41);
    put_char(txtcon_pkg::LF_CHAR);
    put_char(8'h62);
    put_char(txtcon_pkg::CR_CHAR);
    send_beat(txtcon_pkg::MODE_BKSP, 8'h00, 11'h000);
    send_beat(txtcon_pkg::MODE_BKSP, 8'hFF, 11'h7FF);
    read_cell(11'd1);
    read_cell(11'(COLS));
    read_cell(11'(2 * COLS - 1));
  endtask

  task automatic test_clear();
    set_attr(8'h00);
    send_beat(txtcon_pkg::MODE_CLEAR, 8'hA5, 11'h555);
    read_cell(11'd2);
    read_cell(11'(CELLS - 1));
  endtask

  task automatic random_burst();
    int unsigned       kind;
    int unsigned       len;
    txtcon_pkg::mode_t m;
    kind = $urandom_range(99);
    if (kind < 55) begin
      len = $urandom_range(0, 20);
      repeat (len) begin
        if ($urandom_range(9) == 0) read_cell(pick_cell());
        else put_char(text_char());
      end
      put_char($urandom_range(1) ? txtcon_pkg::LF_CHAR : txtcon_pkg::CR_CHAR);
    end else if (kind < 66) begin
      len = $urandom_range(70, 90);
      repeat (len) put_char(text_char());
    end else if (kind < 78) begin
      len = $urandom_range(1, 8);
      repeat (len) send_beat(txtcon_pkg::MODE_BKSP, 8'($urandom_range(255)),
                             11'($urandom_range(2047)));
    end else if (kind < 91) begin
      len = $urandom_range(1, 4);
      repeat (len) read_cell(pick_cell());
    end else if (kind < 99) begin
      len = $urandom_range(1, 6);
      repeat (len) begin
        case ($urandom_range(2))
          0: m = txtcon_pkg::MODE_PUT;
          1: m = txtcon_pkg::MODE_BKSP;
          default: m = txtcon_pkg::MODE_READ;
        endcase
        send_beat(m, 8'($urandom_range(255)), 11'($urandom_range(2047)));
      end
    end else begin
      send_beat(txtcon_pkg::MODE_CLEAR, 8'($urandom_range(255)), 11'($urandom_range(2047)));
    end
  endtask

  task automatic test_random(int unsigned count);
    int unsigned stop_at;
    stop_at = beats_sent + count;
    while (beats_sent < stop_at) random_burst();
  endtask

  // ---- result checking ----

  task automatic check_field(string name, logic [10:0] want, logic [10:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  always @(negedge clk) out_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);

  always @(posedge clk) begin
    cursor_report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (reports_due.size() == 0) begin
        $error("result beat with no expectation pending");
        error_count++;
      end else begin
        want = reports_due.pop_front();
        check_field("cursor_row",    11'(want.row),      11'(out_ch.cursor_row));
        check_field("cursor_col",    11'(want.col),      11'(out_ch.cursor_col));
        check_field("cursor_offset", want.offset,        out_ch.cursor_offset);
        check_field("scrolled",      11'(want.scrolled), 11'(out_ch.scrolled));
        check_field("cell_char",     11'(want.ch),       11'(out_ch.cell_char));
        check_field("cell_attr",     11'(want.attr),     11'(out_ch.cell_attr));
      end
    end
  end

  initial begin
    #40000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 8'h00;
    in_ch.valid      = 1'b0;
    in_ch.mode       = txtcon_pkg::MODE_PUT;
    in_ch.char_code  = 8'h00;
    in_ch.cell_index = 11'h000;
    console_reset();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_power_up();
    test_edit_line();
    test_clear();

    set_attr(8'($urandom_range(255)));
    test_random(460);
    set_attr(8'h00);
    test_random(460);
    set_attr(8'hFF);
    idle_on = 1'b0;
    test_random(460);
    wait_quiet();
    idle_on = 1'b1;
    set_attr(8'($urandom_range(255)));
    test_random(460);

    wait_quiet();
    repeat (SWEEP) @(negedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### text_console_with_scroll_top.f
hw/rtl/txtcon_pkg.sv
hw/rtl/txtcon_if.sv
hw/rtl/txtcon_ram.sv
hw/rtl/txtcon_ctrl.sv
hw/rtl/txtcon_dp.sv
hw/rtl/text_console_with_scroll_top.sv
verif/text_console_with_scroll_top_tb.sv
